### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication, disabled during reset
`define CTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### src/cts_pkg.sv
// Types, constants and arithmetic helpers of the complex Takagi series block.
// No dependencies.
package cts_pkg;

    localparam int TERMS         = 36;
    localparam int FRACTION_BITS = 32;
    // Terms that contribute a nonzero triangle
    localparam int NT     = (TERMS < FRACTION_BITS) ? TERMS : FRACTION_BITS;
    localparam int NTW    = (NT > 1) ? $clog2(NT) : 1;
    localparam int KW     = (TERMS > 1) ? $clog2(TERMS) : 1;
    localparam int TRI_W  = FRACTION_BITS + 1;
    localparam int PROD_W = FRACTION_BITS + 34;
    localparam int TSHIFT = FRACTION_BITS - 2;
    localparam int TERM_W = PROD_W - TSHIFT;
    localparam int SUM_W  = 48;
    localparam int WIDE_W = SUM_W + 2;

    typedef logic [FRACTION_BITS-1:0] frac_t;
    typedef logic [TRI_W-1:0]         tri_t;
    typedef logic signed [31:0]       pow_t;
    typedef logic signed [63:0]       pprod_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam pow_t ONE_Q30 = 32'sh4000_0000;

    typedef enum logic [1:0] {PW_IDLE, PW_MUL, PW_ACC} pw_state_t;

    typedef struct packed {
        sum_t val;
        logic ovf;
    } sum_res_t;

    typedef struct packed {
        frac_t fnext;
        prod_t pr;
        prod_t pi;
        sum_t  sr;
        sum_t  si;
        logic  ovf;
    } stage_t;

    typedef struct packed {
        pow_t val;
        logic ovf;
    } pow_res_t;

    // Align the 32-bit abscissa to the fraction width
    function automatic frac_t to_frac(logic [31:0] p);
        frac_t f;
        int    src;
        for (int i = 0; i < FRACTION_BITS; i++) begin
            src  = i + 32 - FRACTION_BITS;
            f[i] = (src >= 0 && src < 32) ? p[src] : 1'b0;
        end
        return f;
    endfunction

    // Triangle wave in units of 2^-FRACTION_BITS
    // Upper half: 2^(FB+1) - 2f, which wraps correctly in TRI_W bits
    function automatic tri_t tri_of(frac_t f);
        if (f[FRACTION_BITS-1])
            return tri_t'(0) - {f, 1'b0};
        return {f, 1'b0};
    endfunction

    function automatic prod_t mul_term(pow_t pw, tri_t t);
        return prod_t'(pw) * prod_t'($signed({1'b0, t}));
    endfunction

    // Round half up to Q4.32
    function automatic term_t round_term(prod_t p);
        prod_t tmp;
        tmp = p + (prod_t'(1) <<< (TSHIFT - 1));
        return tmp[PROD_W-1:TSHIFT];
    endfunction

    function automatic sum_res_t sat_add(sum_t s, term_t t);
        logic signed [WIDE_W-1:0] w;
        sum_res_t r;
        w = WIDE_W'(s) + WIDE_W'(t);
        r.ovf = (w[WIDE_W-1:SUM_W-1] != {(WIDE_W-SUM_W+1){w[WIDE_W-1]}});
        if (r.ovf)
            r.val = w[WIDE_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            r.val = w[SUM_W-1:0];
        return r;
    endfunction

    // Round half up of (a +/- b) / 2^30, saturated to 32 bits
    function automatic pow_res_t combine_q30(pprod_t a, pprod_t b, logic sub);
        logic signed [65:0] w;
        logic signed [35:0] q;
        pow_res_t r;
        w = sub ? (66'(a) - 66'(b)) : (66'(a) + 66'(b));
        w = w + 66'sd536870912;
        q = w[65:30];
        r.ovf = (q[35:31] != {5{q[35]}});
        if (r.ovf)
            r.val = q[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r.val = q[31:0];
        return r;
    endfunction

    // Fold the previous term into the sums and form the next product
    function automatic stage_t next_stage(stage_t s, pow_t wr, pow_t wi);
        sum_res_t ar;
        sum_res_t ai;
        tri_t     t;
        stage_t   n;
        ar      = sat_add(s.sr, round_term(s.pr));
        ai      = sat_add(s.si, round_term(s.pi));
        t       = tri_of(s.fnext);
        n.fnext = s.fnext << 1;
        n.pr    = mul_term(wr, t);
        n.pi    = mul_term(wi, t);
        n.sr    = ar.val;
        n.si    = ai.val;
        n.ovf   = s.ovf | ar.ovf | ai.ovf;
        return n;
    endfunction

endpackage

### src/complex_takagi_series.sv
// Top level of the complex-weighted Takagi series evaluator.
// Depends on cts_pkg.
//
// Takes one abscissa per clock while in_ready is high and returns one complex Q16.32
// sum per abscissa, through one register stage per nonzero term (the first loads
// at the accepting edge) and the output register; each stage after the first
// holds two 32x34 multipliers and two saturating adds.
// The powers of the weight are formed in turn by a shared complex multiplier,
// each in a multiply state and then an accumulate state: after reset and after
// each weight write, in_ready stays low while the power table is rebuilt.
// A stalled output stalls the whole pipeline.
module complex_takagi_series (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         position,
    output logic                out_valid,
    input  logic                out_ready,
    output cts_pkg::sum_t       sum_real,
    output cts_pkg::sum_t       sum_imag,
    output logic                overflowed
);
    import cts_pkg::*;

    localparam pw_state_t PW_START = (TERMS > 1) ? PW_MUL : PW_IDLE;

    // Weight registers
    pow_t w_re_reg, w_im_reg;
    logic cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? w_im_reg : w_re_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_re_reg <= 32'sh2000_0000;
            w_im_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                w_im_reg <= pwdata;
            else
                w_re_reg <= pwdata;
        end
    end

    // Power table sequencer
    pw_state_t pw_state_reg, pw_state_next;
    logic [KW-1:0] k_reg;
    pow_t   cur_re_reg, cur_im_reg;
    pprod_t p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    pow_t   pow_re_reg [1:NT-1];
    pow_t   pow_im_reg [1:NT-1];
    logic   powovf_reg;
    pow_res_t nr, ni;

    always_comb
    begin
        case (pw_state_reg)
            PW_IDLE: pw_state_next = cfg_wr ? PW_START : PW_IDLE;
            PW_MUL:  pw_state_next = cfg_wr ? PW_START : PW_ACC;
            PW_ACC:
            begin
                if (cfg_wr)
                    pw_state_next = PW_START;
                else if (k_reg == KW'(TERMS - 1))
                    pw_state_next = PW_IDLE;
                else
                    pw_state_next = PW_MUL;
            end
            default: pw_state_next = PW_START;
        endcase
    end

    always_comb
    begin
        nr = combine_q30(p_rr_reg, p_ii_reg, 1'b1);
        ni = combine_q30(p_ri_reg, p_ir_reg, 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_state_reg <= PW_START;
            k_reg        <= KW'(1);
            cur_re_reg   <= ONE_Q30;
            cur_im_reg   <= '0;
            powovf_reg   <= 1'b0;
        end
        else
        begin
            pw_state_reg <= pw_state_next;
            if (cfg_wr)
            begin
                k_reg      <= KW'(1);
                cur_re_reg <= ONE_Q30;
                cur_im_reg <= '0;
                powovf_reg <= 1'b0;
            end
            else if (pw_state_reg == PW_ACC)
            begin
                k_reg      <= k_reg + KW'(1);
                cur_re_reg <= nr.val;
                cur_im_reg <= ni.val;
                powovf_reg <= powovf_reg | nr.ovf | ni.ovf;
            end
        end
    end

    // Products and table writes; powers past the last nonzero term only feed the flag
    always_ff @(posedge clk)
    begin
        if (pw_state_reg == PW_MUL)
        begin
            p_rr_reg <= pprod_t'(cur_re_reg) * pprod_t'(w_re_reg);
            p_ii_reg <= pprod_t'(cur_im_reg) * pprod_t'(w_im_reg);
            p_ri_reg <= pprod_t'(cur_re_reg) * pprod_t'(w_im_reg);
            p_ir_reg <= pprod_t'(cur_im_reg) * pprod_t'(w_re_reg);
        end
        if (pw_state_reg == PW_ACC && !cfg_wr && k_reg < KW'(NT))
        begin
            pow_re_reg[k_reg[NTW-1:0]] <= nr.val;
            pow_im_reg[k_reg[NTW-1:0]] <= ni.val;
        end
    end

    // Term pipeline
    logic   en;
    logic   v_reg [NT];
    stage_t st_reg [NT];
    stage_t st_next [NT];
    sum_res_t fr, fi;
    frac_t  f0;
    tri_t   t0;
    sum_t   sum_real_reg, sum_imag_reg;
    logic   ovf_reg, out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en && (pw_state_reg == PW_IDLE);

    always_comb
    begin
        f0 = to_frac(position);
        t0 = tri_of(f0);
        st_next[0].fnext = f0 << 1;
        st_next[0].pr    = mul_term(ONE_Q30, t0);
        st_next[0].pi    = '0;
        st_next[0].sr    = '0;
        st_next[0].si    = '0;
        st_next[0].ovf   = 1'b0;
        for (int j = 1; j < NT; j++)
            st_next[j] = next_stage(st_reg[j-1], pow_re_reg[j], pow_im_reg[j]);
        fr = sat_add(st_reg[NT-1].sr, round_term(st_reg[NT-1].pr));
        fi = sat_add(st_reg[NT-1].si, round_term(st_reg[NT-1].pi));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NT; j++)
                st_reg[j] <= st_next[j];
            sum_real_reg <= fr.val;
            sum_imag_reg <= fi.val;
            ovf_reg      <= st_reg[NT-1].ovf | fr.ovf | fi.ovf | powovf_reg;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NT; j++)
                v_reg[j] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid && in_ready;
            for (int j = 1; j < NT; j++)
                v_reg[j] <= v_reg[j-1];
            out_valid_reg <= v_reg[NT-1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign sum_real   = sum_real_reg;
    assign sum_imag   = sum_imag_reg;
    assign overflowed = ovf_reg;

endmodule

### src/cts_checker.sv
// Port-level checker for complex_takagi_series, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [47:0] sum_real,
    input logic [47:0] sum_imag,
    input logic        overflowed
);

    logic        stalled;
    logic [96:0] out_payload;

    assign stalled     = out_valid && !out_ready;
    assign out_payload = {sum_real, sum_imag, overflowed};

    // A held result keeps its payload
    `CTS_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(out_payload))

    // A weight write starts a power rebuild, which blocks new transactions
    `CTS_ASSERT_NXT(a_cfg_blocks, clk, rst_n, psel && penable && pwrite && pready, !in_ready)

    // A stalled output stalls the input side
    `CTS_ASSERT_IMP(a_stall_back, clk, rst_n, stalled, !in_ready)

endmodule

bind complex_takagi_series cts_checker u_cts_checker (.*);
